// ===== design/conv_submap_descriptor_generator_macros.svh =====
// Assertion helpers shared by the divider and controller design files. Both expect clk_i and rst_ni in scope.
`ifndef CONV_SUBMAP_DESCRIPTOR_GENERATOR_MACROS_SVH
`define CONV_SUBMAP_DESCRIPTOR_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define CSDG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSDG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/csdg_pkg.sv =====
package csdg_pkg;

  localparam int unsigned KIND_W   = 1;
  localparam int unsigned FILT_W   = 5;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned PAD_W    = 6;
  localparam int unsigned IFM_W    = 13;
  localparam int unsigned SUB_W    = 3;
  localparam int unsigned OFS_W    = 5;
  localparam int unsigned TILE_W   = 4;
  // Raw offset width: the largest wide-mode offset is seven tiles of fifteen taps.
  localparam int unsigned OX_W     = 8;

  localparam int unsigned MAX_SPLIT_DEFAULT = 8;

  // Radix-4 divider: dividend covers the widest field, divisor covers a stride or tile.
  localparam int unsigned DIV_W     = 14;
  localparam int unsigned DIV_STEPS = DIV_W / 2;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned REG_BIT  = 2;

  localparam logic [TILE_W-1:0] WIDE_TILE_RESET  = TILE_W'(3);
  localparam logic [FILT_W-1:0] MAX_DIRECT_RESET = FILT_W'(7);

  typedef enum logic {
    REG_WIDE_TILE  = 1'b0,
    REG_MAX_DIRECT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_FW   = 3'd0,
    OP_FH   = 3'd1,
    OP_PL   = 3'd2,
    OP_PT   = 3'd3,
    OP_PADL = 3'd4,
    OP_PADT = 3'd5,
    OP_IFMW = 3'd6,
    OP_IFMH = 3'd7
  } op_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [FILT_W-1:0] filter_width;
    logic [FILT_W-1:0] filter_height;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic [PAD_W-1:0]  pad_left;
    logic [PAD_W-1:0]  pad_top;
    logic [IFM_W-1:0]  ifm_width;
    logic [IFM_W-1:0]  ifm_height;
  } req_t;

  typedef struct packed {
    logic [SUB_W-1:0]  sub_col;
    logic [SUB_W-1:0]  sub_row;
    logic [OFS_W-1:0]  offset_x;
    logic [OFS_W-1:0]  offset_y;
    logic [FILT_W-1:0] sub_width;
    logic [FILT_W-1:0] sub_height;
    logic [PAD_W-1:0]  sub_pad_left;
    logic [PAD_W-1:0]  sub_pad_top;
    logic [IFM_W-1:0]  sub_ifm_width;
    logic [IFM_W-1:0]  sub_ifm_height;
    logic              last;
  } desc_t;

  typedef struct packed {
    logic load;
    logic div_start;
    op_e  op;
    logic col_clr;
    logic col_inc;
    logic row_inc;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic empty;
    logic col_last;
    logic row_last;
  } sts_t;

endpackage

// ===== design/csdg_req_if.sv =====
interface csdg_req_if import csdg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [FILT_W-1:0] filter_width;
  logic [FILT_W-1:0] filter_height;
  logic [STEP_W-1:0] step_x;
  logic [STEP_W-1:0] step_y;
  logic [PAD_W-1:0]  pad_left;
  logic [PAD_W-1:0]  pad_top;
  logic [IFM_W-1:0]  ifm_width;
  logic [IFM_W-1:0]  ifm_height;

  modport source (
    output valid, kind, filter_width, filter_height, step_x, step_y,
           pad_left, pad_top, ifm_width, ifm_height,
    input  ready
  );
  modport sink (
    input  valid, kind, filter_width, filter_height, step_x, step_y,
           pad_left, pad_top, ifm_width, ifm_height,
    output ready
  );
endinterface

// ===== design/csdg_desc_if.sv =====
interface csdg_desc_if import csdg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SUB_W-1:0]  sub_col;
  logic [SUB_W-1:0]  sub_row;
  logic [OFS_W-1:0]  offset_x;
  logic [OFS_W-1:0]  offset_y;
  logic [FILT_W-1:0] sub_width;
  logic [FILT_W-1:0] sub_height;
  logic [PAD_W-1:0]  sub_pad_left;
  logic [PAD_W-1:0]  sub_pad_top;
  logic [IFM_W-1:0]  sub_ifm_width;
  logic [IFM_W-1:0]  sub_ifm_height;
  logic              last;

  modport source (
    output valid, sub_col, sub_row, offset_x, offset_y, sub_width, sub_height,
           sub_pad_left, sub_pad_top, sub_ifm_width, sub_ifm_height, last,
    input  ready
  );
  modport sink (
    input  valid, sub_col, sub_row, offset_x, offset_y, sub_width, sub_height,
           sub_pad_left, sub_pad_top, sub_ifm_width, sub_ifm_height, last,
    output ready
  );
endinterface

// ===== design/csdg_div.sv =====
`include "conv_submap_descriptor_generator_macros.svh"

module csdg_div import csdg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [STEP_W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DIV_W-1:0]  quotient_o,
  output logic [STEP_W-1:0] remainder_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  dq_q, dq_d;
  logic [STEP_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0] dvs_q, dvs_d;

  logic [STEP_W+1:0] part, d1, d2, d3;
  logic [STEP_W+1:0] part_rem;
  logic [1:0]        digit;

  // Two quotient bits per cycle: compare the partial remainder against 1x, 2x and 3x.
  always_comb begin
    part = {rem_q, dq_q[DIV_W-1 -: 2]};
    d1   = {2'b00, dvs_q};
    d2   = {1'b0, dvs_q, 1'b0};
    d3   = d1 + d2;
    priority if (part >= d3) begin
      digit    = 2'd3;
      part_rem = part - d3;
    end else if (part >= d2) begin
      digit    = 2'd2;
      part_rem = part - d2;
    end else if (part >= d1) begin
      digit    = 2'd1;
      part_rem = part - d1;
    end else begin
      digit    = 2'd0;
      part_rem = part;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = {dq_q[DIV_W-3:0], digit};
      rem_d = part_rem[STEP_W-1:0];
      cnt_d = cnt_q + DCNT_W'(1);
      if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = dq_q;
  assign remainder_o = rem_q;

  `CSDG_ASSERT_IMP(a_div_rem_below, done_q, rem_q < dvs_q, "remainder not below divisor")
  `CSDG_ASSERT_NXT(a_div_start_busy, start_i, busy_q, "divider did not start")
  `CSDG_ASSERT_IMP(a_div_done_idle, done_q, !busy_q, "divider done while still busy")

endmodule

// ===== design/csdg_ctrl.sv =====
`include "conv_submap_descriptor_generator_macros.svh"

module csdg_ctrl import csdg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic desc_valid_o,
  input  logic desc_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    cmd_o         = '0;
    cmd_o.op      = op_q;
    req_ready_o   = 1'b0;
    desc_valid_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = OP_FW;
          state_d    = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_ISSUE;
          unique case (op_q)
            OP_FW:   op_d = OP_FH;
            OP_FH:   op_d = OP_PL;
            OP_PL:   op_d = OP_PT;
            OP_PT: begin
              // A wide split of a zero-tap side yields an empty grid.
              if (sts_i.empty) begin
                state_d = S_IDLE;
              end else begin
                op_d = OP_PADT;
              end
            end
            OP_PADT: op_d = OP_IFMH;
            OP_IFMH: op_d = OP_PADL;
            OP_PADL: op_d = OP_IFMW;
            OP_IFMW: state_d = S_OUT;
          endcase
        end
      end
      S_OUT: begin
        desc_valid_o = 1'b1;
        if (desc_ready_i) begin
          if (sts_i.col_last) begin
            if (sts_i.row_last) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.row_inc = 1'b1;
              cmd_o.col_clr = 1'b1;
              op_d          = OP_PADT;
              state_d       = S_ISSUE;
            end
          end else begin
            cmd_o.col_inc = 1'b1;
            op_d          = OP_PADL;
            state_d       = S_ISSUE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_FW;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  `CSDG_ASSERT_IMP(a_ctrl_start_free, cmd_o.div_start, !sts_i.div_busy, "divide issued while busy")
  `CSDG_ASSERT_NXT(a_ctrl_last_idle,
    desc_valid_o && desc_ready_i && sts_i.col_last && sts_i.row_last,
    state_q == S_IDLE, "no return to idle after final descriptor")
  `CSDG_ASSERT_IMP(a_ctrl_out_quiet, state_q == S_OUT,
    !sts_i.div_busy && !sts_i.div_done, "divider active while a descriptor is offered")

endmodule

// ===== design/csdg_dp.sv =====
module csdg_dp import csdg_pkg::*; #(
  parameter int unsigned MAX_SPLIT = MAX_SPLIT_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  req_t              req_i,
  input  logic [TILE_W-1:0] cfg_tile_i,
  input  logic [FILT_W-1:0] cfg_max_direct_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output desc_t             desc_o
);

  localparam int unsigned IdxW = (MAX_SPLIT > 1) ? $clog2(MAX_SPLIT) : 1;
  localparam int unsigned CntW = $clog2(MAX_SPLIT + 1);
  localparam logic [CntW-1:0] Limit = CntW'(MAX_SPLIT);

  req_t              req_q;
  logic [FILT_W-1:0] fwq_q, fhq_q;
  logic              fwr_nz_q, fhr_nz_q;
  logic [OX_W-1:0]   ox0_q, oy0_q, ox_q, oy_q;
  logic [PAD_W-1:0]  padl_q, padt_q;
  logic [IFM_W-1:0]  ifmw_q, ifmh_q;
  logic [IdxW-1:0]   col_q, row_q;

  logic [STEP_W-1:0] tile_eff, sxe, sye, dvs;
  logic [FILT_W-1:0] tx, ty;
  logic              wide;
  logic [DIV_W-1:0]  dvd, quo, ceil_q;
  logic [STEP_W-1:0] rem;
  logic              div_busy, div_done;
  logic [OX_W-1:0]   pl_left, pt_left, ox_next, oy_next;
  logic [IFM_W-1:0]  iw_left, ih_left;
  logic [FILT_W:0]   fw_ceil, fh_ceil;
  logic [CntW-1:0]   cols, rows;

  // Effective strides: a zero step acts as one; the wide split always steps by one tap.
  always_comb begin
    tile_eff = (cfg_tile_i == '0) ? STEP_W'(1) : cfg_tile_i;
    sxe = req_q.kind[0] ? STEP_W'(1) : ((req_q.step_x == '0) ? STEP_W'(1) : req_q.step_x);
    sye = req_q.kind[0] ? STEP_W'(1) : ((req_q.step_y == '0) ? STEP_W'(1) : req_q.step_y);
    wide = (req_q.filter_width > cfg_max_direct_i) || (req_q.filter_height > cfg_max_direct_i);
    tx = wide ? ((req_q.filter_width == FILT_W'(1)) ? FILT_W'(1) : FILT_W'(tile_eff))
              : req_q.filter_width;
    ty = wide ? ((req_q.filter_height == FILT_W'(1)) ? FILT_W'(1) : FILT_W'(tile_eff))
              : req_q.filter_height;
  end

  always_comb begin
    pl_left = (OX_W'(req_q.pad_left) > ox_q) ? OX_W'(req_q.pad_left) - ox_q : '0;
    pt_left = (OX_W'(req_q.pad_top) > oy_q) ? OX_W'(req_q.pad_top) - oy_q : '0;
    iw_left = (req_q.ifm_width > IFM_W'(col_q)) ? req_q.ifm_width - IFM_W'(col_q) : '0;
    ih_left = (req_q.ifm_height > IFM_W'(row_q)) ? req_q.ifm_height - IFM_W'(row_q) : '0;
  end

  always_comb begin
    unique case (cmd_i.op)
      OP_FW: begin
        dvd = DIV_W'(req_q.filter_width);
        dvs = req_q.kind[0] ? tile_eff : sxe;
      end
      OP_FH: begin
        dvd = DIV_W'(req_q.filter_height);
        dvs = req_q.kind[0] ? tile_eff : sye;
      end
      OP_PL: begin
        dvd = DIV_W'(req_q.pad_left);
        dvs = sxe;
      end
      OP_PT: begin
        dvd = DIV_W'(req_q.pad_top);
        dvs = sye;
      end
      OP_PADL: begin
        dvd = DIV_W'(pl_left);
        dvs = sxe;
      end
      OP_PADT: begin
        dvd = DIV_W'(pt_left);
        dvs = sye;
      end
      OP_IFMW: begin
        dvd = DIV_W'(iw_left);
        dvs = sxe;
      end
      OP_IFMH: begin
        dvd = DIV_W'(ih_left);
        dvs = sye;
      end
    endcase
  end

  csdg_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (dvd),
    .divisor_i   (dvs),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  assign ceil_q = quo + DIV_W'(rem != '0);

  // Strided offsets wrap modulo the step; wide offsets advance one tile at a time.
  always_comb begin
    ox_next = req_q.kind[0] ? ox_q + OX_W'(tx)
            : ((ox_q == OX_W'(sxe) - OX_W'(1)) ? '0 : ox_q + OX_W'(1));
    oy_next = req_q.kind[0] ? oy_q + OX_W'(ty)
            : ((oy_q == OX_W'(sye) - OX_W'(1)) ? '0 : oy_q + OX_W'(1));
  end

  // Grid size per axis, capped at MAX_SPLIT.
  always_comb begin
    fw_ceil = {1'b0, fwq_q} + (FILT_W + 1)'(fwr_nz_q);
    fh_ceil = {1'b0, fhq_q} + (FILT_W + 1)'(fhr_nz_q);
    if (!req_q.kind[0]) begin
      cols = ((STEP_W + 1)'(sxe) > (STEP_W + 1)'(MAX_SPLIT)) ? Limit : CntW'(sxe);
      rows = ((STEP_W + 1)'(sye) > (STEP_W + 1)'(MAX_SPLIT)) ? Limit : CntW'(sye);
    end else begin
      if (!wide || req_q.filter_width == FILT_W'(1)) begin
        cols = CntW'(1);
      end else begin
        cols = (fw_ceil > (FILT_W + 1)'(MAX_SPLIT)) ? Limit : CntW'(fw_ceil);
      end
      if (!wide || req_q.filter_height == FILT_W'(1)) begin
        rows = CntW'(1);
      end else begin
        rows = (fh_ceil > (FILT_W + 1)'(MAX_SPLIT)) ? Limit : CntW'(fh_ceil);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (div_done) begin
      unique case (cmd_i.op)
        OP_FW: begin
          fwq_q    <= quo[FILT_W-1:0];
          fwr_nz_q <= (rem != '0);
        end
        OP_FH: begin
          fhq_q    <= quo[FILT_W-1:0];
          fhr_nz_q <= (rem != '0);
        end
        OP_PL: begin
          ox0_q <= req_q.kind[0] ? '0 : OX_W'(rem);
          ox_q  <= req_q.kind[0] ? '0 : OX_W'(rem);
        end
        OP_PT: begin
          oy0_q <= req_q.kind[0] ? '0 : OX_W'(rem);
          oy_q  <= req_q.kind[0] ? '0 : OX_W'(rem);
        end
        OP_PADL: padl_q <= ceil_q[PAD_W-1:0];
        OP_PADT: padt_q <= ceil_q[PAD_W-1:0];
        OP_IFMW: ifmw_q <= ceil_q[IFM_W-1:0];
        OP_IFMH: ifmh_q <= ceil_q[IFM_W-1:0];
      endcase
    end else begin
      if (cmd_i.col_clr) begin
        ox_q <= ox0_q;
      end else if (cmd_i.col_inc) begin
        ox_q <= ox_next;
      end
      if (cmd_i.row_inc) begin
        oy_q <= oy_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      if (cmd_i.load || cmd_i.col_clr) begin
        col_q <= '0;
      end else if (cmd_i.col_inc) begin
        col_q <= col_q + IdxW'(1);
      end
      if (cmd_i.load) begin
        row_q <= '0;
      end else if (cmd_i.row_inc) begin
        row_q <= row_q + IdxW'(1);
      end
    end
  end

  always_comb begin
    sts_o.div_done = div_done;
    sts_o.div_busy = div_busy;
    sts_o.empty    = (cols == '0) || (rows == '0);
    sts_o.col_last = ((CntW'(col_q) + CntW'(1)) == cols);
    sts_o.row_last = ((CntW'(row_q) + CntW'(1)) == rows);
  end

  always_comb begin
    desc_o.sub_col  = SUB_W'(col_q);
    desc_o.sub_row  = SUB_W'(row_q);
    desc_o.offset_x = (|ox_q[OX_W-1:OFS_W]) ? '1 : ox_q[OFS_W-1:0];
    desc_o.offset_y = (|oy_q[OX_W-1:OFS_W]) ? '1 : oy_q[OFS_W-1:0];
    if (req_q.kind[0]) begin
      desc_o.sub_width  = tx;
      desc_o.sub_height = ty;
    end else begin
      // The column whose offset is the last phase of the step gets the floor size.
      desc_o.sub_width  = ((ox_q == OX_W'(sxe) - OX_W'(1)) || !fwr_nz_q) ? fwq_q
                        : fwq_q + FILT_W'(1);
      desc_o.sub_height = ((oy_q == OX_W'(sye) - OX_W'(1)) || !fhr_nz_q) ? fhq_q
                        : fhq_q + FILT_W'(1);
    end
    desc_o.sub_pad_left   = padl_q;
    desc_o.sub_pad_top    = padt_q;
    desc_o.sub_ifm_width  = ifmw_q;
    desc_o.sub_ifm_height = ifmh_q;
    desc_o.last           = sts_o.col_last && sts_o.row_last;
  end

endmodule

// ===== design/conv_submap_descriptor_generator.sv =====
// Splits one convolution request into sub-filter descriptors, emitted row by row with the
// column index running fastest; the final one carries last. One request is handled at a
// time: the request port is ready only between requests. All divisions by stride or tile
// go through one shared radix-4 divider, one operation at a time, and that divider sets
// the pace of a request together with any output stall. A wide split of a zero-tap side
// gives no descriptors at all. Configuration registers live at byte addresses 0 (wide
// tile size) and 4 (largest direct filter side) on the APB port.
module conv_submap_descriptor_generator import csdg_pkg::*; #(
  parameter int unsigned MAX_SPLIT = MAX_SPLIT_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  csdg_req_if.sink          req_i,
  csdg_desc_if.source       desc_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [TILE_W-1:0] tile_q;
  logic [FILT_W-1:0] max_direct_q;
  logic              cfg_wr;
  reg_idx_e          reg_idx;

  req_t  req;
  desc_t desc;
  cmd_t  cmd;
  sts_t  sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[REG_BIT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_q       <= WIDE_TILE_RESET;
      max_direct_q <= MAX_DIRECT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDE_TILE:  tile_q       <= pwdata[TILE_W-1:0];
        REG_MAX_DIRECT: max_direct_q <= pwdata[FILT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDE_TILE:  prdata = APB_DW'(tile_q);
      REG_MAX_DIRECT: prdata = APB_DW'(max_direct_q);
    endcase
  end

  always_comb begin
    req.kind          = req_i.kind;
    req.filter_width  = req_i.filter_width;
    req.filter_height = req_i.filter_height;
    req.step_x        = req_i.step_x;
    req.step_y        = req_i.step_y;
    req.pad_left      = req_i.pad_left;
    req.pad_top       = req_i.pad_top;
    req.ifm_width     = req_i.ifm_width;
    req.ifm_height    = req_i.ifm_height;
  end

  csdg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .desc_valid_o (desc_o.valid),
    .desc_ready_i (desc_o.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  csdg_dp #(
    .MAX_SPLIT (MAX_SPLIT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .cfg_tile_i       (tile_q),
    .cfg_max_direct_i (max_direct_q),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .desc_o           (desc)
  );

  assign desc_o.sub_col        = desc.sub_col;
  assign desc_o.sub_row        = desc.sub_row;
  assign desc_o.offset_x       = desc.offset_x;
  assign desc_o.offset_y       = desc.offset_y;
  assign desc_o.sub_width      = desc.sub_width;
  assign desc_o.sub_height     = desc.sub_height;
  assign desc_o.sub_pad_left   = desc.sub_pad_left;
  assign desc_o.sub_pad_top    = desc.sub_pad_top;
  assign desc_o.sub_ifm_width  = desc.sub_ifm_width;
  assign desc_o.sub_ifm_height = desc.sub_ifm_height;
  assign desc_o.last           = desc.last;

endmodule
